// ===== design/ccbp_pkg.sv =====
`default_nettype none

package ccbp_pkg;

	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_INT   = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam int CODE_W    = 10;
	localparam int LEN_W     = 4;
	localparam int ACC_W     = 39;
	localparam int MAX_BYTES = 4;

	localparam logic [5:0] ESC_CODE = 6'd63;
	localparam logic [3:0] SUB_OTHER = 4'd15;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} char_map_t;

	typedef struct packed {
		logic [8*MAX_BYTES-1:0] bytes;
		logic [2:0]             nbytes;
		logic                   bad;
		logic [6:0]             nxt_bits;
		logic [2:0]             nxt_count;
	} pack_res_t;

	function automatic char_map_t map_char(input logic [7:0] c, input logic upper);
		char_map_t  r;
		logic [5:0] x;
		logic [3:0] sub;
		logic       esc;
		logic       bad;
		x   = '0;
		sub = '0;
		esc = 1'b0;
		bad = 1'b0;
		priority if (c >= 8'h41 && c <= 8'h5a) begin
			x = 6'(c - 8'h41);
		end else if (c == 8'h2d) begin
			x = 6'd26;
		end else if (c == 8'h5f) begin
			x = 6'd27;
		end else if (c == 8'h25) begin
			x = 6'd28;
		end else if (c == 8'h20) begin
			x = 6'd29;
		end else if (c == 8'h2f) begin
			x = 6'd30;
		end else if (c == 8'h00) begin
			x = 6'd31;
		end else if (upper) begin
			bad = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			x = 6'(c - 8'h61) + 6'd32;
		end else if (c == 8'h28) begin
			x = 6'd58;
		end else if (c == 8'h29) begin
			x = 6'd59;
		end else if (c == 8'h26) begin
			x = 6'd60;
		end else if (c == 8'h2b) begin
			x = 6'd61;
		end else if (c == 8'h2c) begin
			x = 6'd62;
		end else begin
			esc = 1'b1;
			priority if (c >= 8'h30 && c <= 8'h39) begin
				sub = 4'(c - 8'h30);
			end else if (c == 8'h2e) begin
				sub = 4'd10;
			end else if (c == 8'h27) begin
				sub = 4'd11;
			end else begin
				sub = SUB_OTHER;
			end
		end
		if (bad) begin
			r.len  = 4'd0;
			r.code = '0;
		end else if (esc) begin
			r.len  = 4'd10;
			r.code = {sub, ESC_CODE};
		end else begin
			r.len  = upper ? 4'd5 : 4'd6;
			r.code = {4'd0, x};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/char_code_bit_packer_top.sv =====
// character code bit packer
// input channel: in_valid/in_stall with op, char_code, upper_only, int_value,
// int_width; a transfer happens when in_valid is high and in_stall is low
// output channel: out_valid/out_stall with out_byte, byte_valid, bad_char, last
// each input item gives 1 to 4 results; last marks the final one of the item
// an item that completes no byte gives one result with byte_valid low
// each item passes through the input register and then the result buffer
// throughput, with out_stall low: one item per cycle when each item gives one
// result; an n-byte item holds the result buffer, sending one byte per cycle
// the input register takes the next item while results are still draining
// receiver stall holds the current result and, once the input register is
// full, raises in_stall
// reset clears the partial byte, its bit count and all valid flags
`default_nettype none

module char_code_bit_packer_top
	import ccbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  char_code,
	input  wire logic        upper_only,
	input  wire logic [31:0] int_value,
	input  wire logic [5:0]  int_width,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             bad_char,
	output logic             last
);

	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [7:0]  char_s1;
	logic        upper_s1;
	logic [31:0] ival_s1;
	logic [5:0]  iw_s1;

	logic [6:0]  pend_bits_q;
	logic [2:0]  pend_count_q;

	logic                   ob_valid_q;
	logic [8*MAX_BYTES-1:0] ob_bytes_q;
	logic [1:0]             ob_last_idx_q;
	logic [1:0]             ob_idx_q;
	logic                   ob_has_byte_q;
	logic                   ob_bad_q;

	pack_res_t res;
	logic      out_xfer;
	logic      ob_done;
	logic      load;
	logic      in_xfer;

	ccbp_pack u_pack (
		.op         (op_s1),
		.char_code  (char_s1),
		.upper_only (upper_s1),
		.int_value  (ival_s1),
		.int_width  (iw_s1),
		.pend_bits  (pend_bits_q),
		.pend_count (pend_count_q),
		.res        (res)
	);

	assign out_xfer = ob_valid_q & ~out_stall;
	assign ob_done  = out_xfer & (ob_idx_q == ob_last_idx_q);
	assign load     = vld_s1 & (~ob_valid_q | ob_done);
	assign in_stall = vld_s1 & ~load;
	assign in_xfer  = in_valid & ~in_stall;

	assign out_valid  = ob_valid_q;
	assign byte_valid = ob_has_byte_q;
	assign bad_char   = ob_bad_q;
	assign last       = (ob_idx_q == ob_last_idx_q);
	assign out_byte   = ob_has_byte_q ? ob_bytes_q[{ob_idx_q, 3'b000} +: 8] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= op;
			char_s1  <= char_code;
			upper_s1 <= upper_only;
			ival_s1  <= int_value;
			iw_s1    <= int_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q   <= '0;
			pend_count_q  <= '0;
			ob_valid_q    <= 1'b0;
			ob_idx_q      <= '0;
			ob_last_idx_q <= '0;
			ob_has_byte_q <= 1'b0;
			ob_bad_q      <= 1'b0;
		end else if (load) begin
			pend_bits_q   <= res.nxt_bits;
			pend_count_q  <= res.nxt_count;
			ob_valid_q    <= 1'b1;
			ob_idx_q      <= '0;
			ob_last_idx_q <= (res.nbytes == 3'd0) ? 2'd0 : 2'(res.nbytes - 3'd1);
			ob_has_byte_q <= (res.nbytes != 3'd0);
			ob_bad_q      <= res.bad;
		end else if (ob_done) begin
			ob_valid_q <= 1'b0;
		end else if (out_xfer) begin
			ob_idx_q <= ob_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_bytes_q <= res.bytes;
		end
	end

endmodule

`default_nettype wire

// ===== design/ccbp_pack.sv =====
`default_nettype none

module ccbp_pack
	import ccbp_pkg::*;
(
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  char_code,
	input  wire logic        upper_only,
	input  wire logic [31:0] int_value,
	input  wire logic [5:0]  int_width,
	input  wire logic [6:0]  pend_bits,
	input  wire logic [2:0]  pend_count,
	output pack_res_t        res
);

	char_map_t        cm;
	logic [5:0]       iw_sat;
	logic [31:0]      int_mask;
	logic [31:0]      code;
	logic [5:0]       len;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] rest;
	logic [5:0]       total;
	logic             is_bad;

	always_comb begin
		cm       = map_char(char_code, upper_only);
		iw_sat   = (int_width > 6'd32) ? 6'd32 : int_width;
		int_mask = ~(32'hffff_ffff << iw_sat);
		code     = '0;
		len      = '0;
		is_bad   = 1'b0;
		unique case (op_t'(op))
			OP_CHAR: begin
				code   = {22'd0, cm.code};
				len    = {2'd0, cm.len};
				is_bad = (cm.len == 4'd0);
			end
			OP_INT: begin
				code = int_value & int_mask;
				len  = iw_sat;
			end
			OP_FLUSH, OP_NONE: begin
				code = '0;
				len  = '0;
			end
			default: begin
				code = '0;
				len  = '0;
			end
		endcase

		acc   = {32'd0, pend_bits} | ({7'd0, code} << pend_count);
		total = {3'd0, pend_count} + len;
		rest  = acc >> {total[5:3], 3'b000};

		res.bad = is_bad;
		if (op_t'(op) == OP_FLUSH) begin
			res.bytes     = {24'd0, 1'b0, pend_bits};
			res.nbytes    = (pend_count != 3'd0) ? 3'd1 : 3'd0;
			res.nxt_bits  = '0;
			res.nxt_count = '0;
		end else begin
			res.bytes     = acc[8*MAX_BYTES-1:0];
			res.nbytes    = total[5:3];
			res.nxt_bits  = rest[6:0];
			res.nxt_count = total[2:0];
		end
	end

endmodule

`default_nettype wire
